[hw/rtl/satfo_pkg.sv]
package satfo_pkg;

    localparam int ADDR_W    = 64;
    localparam int TYPE_W    = 32;
    localparam int CNT_W     = 7;
    localparam int IDX_W     = 6;
    localparam int CFG_IDX_W = 3;
    localparam int TSIZE_W   = 2 * CNT_W;

    // one table entry as stored: start, length, file offset, skippable
    localparam int ENTRY_W = 3 * ADDR_W + 1;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_EXEC_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_BYTES  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE   = 3'd4;

    localparam logic [CNT_W-1:0] ENTRY_BYTES_RST = 7'd64;

    localparam logic [TYPE_W-1:0] TYPE_NULL   = 32'd0;
    localparam logic [TYPE_W-1:0] TYPE_NOBITS = 32'd8;

    typedef struct packed {
        logic load_wr;
        logic query_start;
        logic check;
        logic rd_en;
        logic capture;
        logic out_load;
        logic found;
    } t_cmd;

    typedef struct packed {
        logic fits;
        logic hit;
    } t_status;

endpackage

[hw/rtl/satfo_ram.sv]
module satfo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/satfo_dp.sv]
module satfo_dp
    import satfo_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    parameter int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data,
    input  logic [IDX_W-1:0]     i_entry_index,
    input  logic [ADDR_W-1:0]    i_entry_address,
    input  logic [ADDR_W-1:0]    i_entry_length,
    input  logic [ADDR_W-1:0]    i_entry_file_offset,
    input  logic [TYPE_W-1:0]    i_entry_type,
    input  logic [ADDR_W-1:0]    i_query_address,
    input  t_cmd                 i_cmd,
    input  logic [AW-1:0]        i_rd_addr,
    output t_status              o_status,
    output logic [CW-1:0]        o_walk_len,
    output logic                 o_found,
    output logic [ADDR_W-1:0]    o_file_offset
);

    logic                r_exec_mode;
    logic [ADDR_W-1:0]   r_table_offset;
    logic [CNT_W-1:0]    r_entry_count;
    logic [CNT_W-1:0]    r_entry_bytes;
    logic [ADDR_W-1:0]   r_image_size;

    logic [ADDR_W-1:0]   r_qaddr;
    logic [TSIZE_W-1:0]  r_tsize;
    logic [CW-1:0]       r_walk_len;
    logic                r_fits;
    logic [ADDR_W-1:0]   r_diff;
    logic [ADDR_W-1:0]   r_fo;
    logic                r_found;
    logic [ADDR_W-1:0]   r_offset;

    logic [31:0]         w_idx32;
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic                w_skip_in;
    logic [ENTRY_W-1:0]  w_wdata;
    logic [ENTRY_W-1:0]  w_rdata;
    logic [ADDR_W-1:0]   w_start;
    logic [ADDR_W-1:0]   w_len;
    logic [ADDR_W-1:0]   w_fo;
    logic                w_skip;
    logic [ADDR_W:0]     w_sub;
    logic                w_hit;
    logic [ADDR_W:0]     w_end;
    logic                w_fits;
    logic [31:0]         w_cnt32;
    logic [31:0]         w_walk32;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exec_mode    <= 1'b0;
            r_table_offset <= '0;
            r_entry_count  <= '0;
            r_entry_bytes  <= ENTRY_BYTES_RST;
            r_image_size   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_EXEC_MODE:    r_exec_mode    <= i_cfg_data[0];
                CFG_TABLE_OFFSET: r_table_offset <= i_cfg_data;
                CFG_ENTRY_COUNT:  r_entry_count  <= i_cfg_data[CNT_W-1:0];
                CFG_ENTRY_BYTES:  r_entry_bytes  <= i_cfg_data[CNT_W-1:0];
                CFG_IMAGE_SIZE:   r_image_size   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // table store
    assign w_idx32   = 32'(i_entry_index);
    assign w_we      = i_cmd.load_wr && (w_idx32 < 32'(TABLE_DEPTH));
    assign w_waddr   = w_idx32[AW-1:0];
    assign w_skip_in = (i_entry_type == TYPE_NULL) || (i_entry_type == TYPE_NOBITS);
    assign w_wdata   = {i_entry_address, i_entry_length, i_entry_file_offset, w_skip_in};

    satfo_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_rd_addr),
        .o_rdata (w_rdata)
    );

    assign {w_start, w_len, w_fo, w_skip} = w_rdata;

    // hit test on the entry just read
    assign w_sub = {1'b0, r_qaddr} - {1'b0, w_start};
    assign w_hit = !(w_skip && !r_exec_mode) && !w_sub[ADDR_W]
                   && (w_sub[ADDR_W-1:0] < w_len);

    // table bounds check
    assign w_end  = {1'b0, r_table_offset} + (ADDR_W + 1)'(r_tsize);
    assign w_fits = (r_table_offset != '0) && !w_end[ADDR_W]
                    && (w_end[ADDR_W-1:0] <= r_image_size) && (r_entry_count != '0);

    assign w_cnt32  = 32'(r_entry_count);
    assign w_walk32 = (w_cnt32 > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : w_cnt32;

    always_ff @(posedge i_clk) begin
        if (i_cmd.query_start) begin
            r_qaddr    <= i_query_address;
            r_tsize    <= TSIZE_W'(r_entry_bytes) * TSIZE_W'(r_entry_count);
            r_walk_len <= w_walk32[CW-1:0];
        end
        if (i_cmd.check) begin
            r_fits <= w_fits;
        end
        if (i_cmd.capture) begin
            r_diff <= w_sub[ADDR_W-1:0];
            r_fo   <= w_fo;
        end
        if (i_cmd.out_load) begin
            r_found  <= i_cmd.found;
            r_offset <= i_cmd.found ? (r_fo + r_diff) : '0;
        end
    end

    assign o_status.fits = r_fits;
    assign o_status.hit  = w_hit;
    assign o_walk_len    = r_walk_len;
    assign o_found       = r_found;
    assign o_file_offset = r_offset;

endmodule

[hw/rtl/satfo_ctrl.sv]
module satfo_ctrl
    import satfo_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    parameter int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_kind,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  t_status       i_status,
    input  logic [CW-1:0] i_walk_len,
    output t_cmd          o_cmd,
    output logic [AW-1:0] o_rd_addr
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_WALK,
        S_DONE
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_idx;
    logic          r_pend;
    logic          r_found;
    logic          r_out_valid;

    logic w_in_acc;
    logic w_issue;
    logic w_out_free;

    assign w_in_acc   = (r_state == S_IDLE) && i_in_valid;
    assign w_issue    = (r_state == S_WALK) && i_status.fits && (r_idx < i_walk_len);
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign o_cmd.load_wr     = w_in_acc && (i_kind == KIND_LOAD);
    assign o_cmd.query_start = w_in_acc && (i_kind == KIND_QUERY);
    assign o_cmd.check       = (r_state == S_CHECK);
    assign o_cmd.rd_en       = w_issue;
    assign o_cmd.capture     = (r_state == S_WALK) && r_pend && i_status.hit;
    assign o_cmd.out_load    = (r_state == S_DONE) && w_out_free;
    assign o_cmd.found       = r_found;

    assign o_rd_addr   = r_idx[AW-1:0];
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd.query_start) begin
                        r_state <= S_CHECK;
                        r_idx   <= '0;
                        r_pend  <= 1'b0;
                        r_found <= 1'b0;
                    end
                end
                S_CHECK: begin
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    r_pend <= w_issue;
                    if (w_issue) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    // stop on failed check, first hit, or end of table
                    priority if (!i_status.fits) begin
                        r_state <= S_DONE;
                        r_found <= 1'b0;
                    end else if (r_pend && i_status.hit) begin
                        r_state <= S_DONE;
                        r_found <= 1'b1;
                    end else if (!r_pend && !w_issue) begin
                        r_state <= S_DONE;
                        r_found <= 1'b0;
                    end else begin
                        r_state <= S_WALK;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[hw/rtl/segment_address_to_file_offset.sv]
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_stall    i_kind, i_entry_*, i_query_address
// out       output     o_out_valid / i_out_stall  o_found, o_file_offset
// cfg       input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// A load item writes one table row; it gives no result.
// A query checks the table bounds, then reads the entries in order, one table RAM read a cycle,
// over n = min(entry_count, TABLE_DEPTH) entries; it stops at the first hit, after the last
// entry read, or when the table check fails, and its result then goes to the output register.
// Reset is synchronous and active low; it clears control and configuration only.
// The next item is accepted while a result still waits in the output register;
// a query finishing behind a stalled result holds until that result is taken.
module segment_address_to_file_offset
    import satfo_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_kind,
    input  logic [IDX_W-1:0]     i_entry_index,
    input  logic [ADDR_W-1:0]    i_entry_address,
    input  logic [ADDR_W-1:0]    i_entry_length,
    input  logic [ADDR_W-1:0]    i_entry_file_offset,
    input  logic [TYPE_W-1:0]    i_entry_type,
    input  logic [ADDR_W-1:0]    i_query_address,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_found,
    output logic [ADDR_W-1:0]    o_file_offset
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_cmd          w_cmd;
    t_status       w_status;
    logic [CW-1:0] w_walk_len;
    logic [AW-1:0] w_rd_addr;

    satfo_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_kind),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .i_walk_len  (w_walk_len),
        .o_cmd       (w_cmd),
        .o_rd_addr   (w_rd_addr)
    );

    satfo_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW),
        .CW          (CW)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_entry_index       (i_entry_index),
        .i_entry_address     (i_entry_address),
        .i_entry_length      (i_entry_length),
        .i_entry_file_offset (i_entry_file_offset),
        .i_entry_type        (i_entry_type),
        .i_query_address     (i_query_address),
        .i_cmd               (w_cmd),
        .i_rd_addr           (w_rd_addr),
        .o_status            (w_status),
        .o_walk_len          (w_walk_len),
        .o_found             (o_found),
        .o_file_offset       (o_file_offset)
    );

    a_query_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_kind == KIND_QUERY)) |=> o_in_stall)
        else $error("input not held after query item");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_file_offset == '0))
        else $error("miss item carries nonzero offset");

    a_result_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result item without a query in progress");

    a_no_load_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rd_en |-> (!w_cmd.load_wr && o_in_stall))
        else $error("table read outside a query walk");

endmodule

[dv/testbench.sv]
module testbench;
    import satfo_pkg::*;

    localparam int DEPTH        = 64;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int ITEM_TARGET  = 1950;

    localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

    typedef struct {
        logic              kind;
        logic [IDX_W-1:0]  index;
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] length;
        logic [ADDR_W-1:0] foff;
        logic [TYPE_W-1:0] etype;
        logic [ADDR_W-1:0] qaddr;
    } t_item;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] offset;
    } t_xlat;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} t_stall_mode;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [ADDR_W-1:0]    i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_kind;
    logic [IDX_W-1:0]     i_entry_index;
    logic [ADDR_W-1:0]    i_entry_address;
    logic [ADDR_W-1:0]    i_entry_length;
    logic [ADDR_W-1:0]    i_entry_file_offset;
    logic [TYPE_W-1:0]    i_entry_type;
    logic [ADDR_W-1:0]    i_query_address;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_found;
    logic [ADDR_W-1:0]    o_file_offset;

    segment_address_to_file_offset #(
        .TABLE_DEPTH(DEPTH)
    ) u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_kind             (i_kind),
        .i_entry_index      (i_entry_index),
        .i_entry_address    (i_entry_address),
        .i_entry_length     (i_entry_length),
        .i_entry_file_offset(i_entry_file_offset),
        .i_entry_type       (i_entry_type),
        .i_query_address    (i_query_address),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_found            (o_found),
        .o_file_offset      (o_file_offset)
    );

    // shadow of the segment table and registers
    logic [ADDR_W-1:0] seg_start [DEPTH];
    logic [ADDR_W-1:0] seg_len   [DEPTH];
    logic [ADDR_W-1:0] seg_foff  [DEPTH];
    logic              seg_skip  [DEPTH];
    logic              mode_exec       = 1'b0;
    logic [ADDR_W-1:0] tbl_offset      = '0;
    logic [CNT_W-1:0]  tbl_count       = '0;
    logic [CNT_W-1:0]  tbl_entry_bytes = ENTRY_BYTES_RST;
    logic [ADDR_W-1:0] img_size        = '0;

    t_xlat pending_offsets [$];
    t_xlat want;

    int  n_fail     = 0;
    int  n_items    = 0;
    int  n_loads    = 0;
    int  n_queries  = 0;
    int  n_results  = 0;
    int  n_hits     = 0;
    int  n_configs  = 0;
    int  burst_left = 0;
    bit  gappy      = 1'b1;
    bit  hold_req   = 1'b0;
    int  load_pct   = 25;

    function automatic logic [ADDR_W-1:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic table_in_bounds();
        logic [TSIZE_W-1:0] tsize;
        logic [ADDR_W:0]    table_end;
        tsize     = tbl_entry_bytes * tbl_count;
        table_end = {1'b0, tbl_offset} + tsize;
        return tbl_offset != '0 && !table_end[ADDR_W] &&
               table_end <= {1'b0, img_size} && tbl_count != '0;
    endfunction

    function automatic t_xlat translate_address(logic [ADDR_W-1:0] addr);
        t_xlat             r;
        int                n;
        logic [ADDR_W-1:0] delta;
        r = '0;
        if (!table_in_bounds()) return r;
        n = (tbl_count > DEPTH) ? DEPTH : int'(tbl_count);
        for (int i = 0; i < n; i++) begin
            delta = addr - seg_start[i];
            if ((mode_exec || !seg_skip[i]) && addr >= seg_start[i] && delta < seg_len[i]) begin
                r.found  = 1'b1;
                r.offset = seg_foff[i] + delta;
                return r;
            end
        end
        return r;
    endfunction

    function automatic t_item load_item(int idx, logic [ADDR_W-1:0] start,
                                        logic [ADDR_W-1:0] length, logic [ADDR_W-1:0] foff,
                                        logic [TYPE_W-1:0] etype);
        t_item it;
        it.kind   = KIND_LOAD;
        it.index  = idx[IDX_W-1:0];
        it.start  = start;
        it.length = length;
        it.foff   = foff;
        it.etype  = etype;
        it.qaddr  = rand64();
        return it;
    endfunction

    function automatic t_item query_item(logic [ADDR_W-1:0] addr);
        t_item it;
        it.kind   = KIND_QUERY;
        it.index  = IDX_W'($urandom());
        it.start  = rand64();
        it.length = rand64();
        it.foff   = rand64();
        it.etype  = $urandom();
        it.qaddr  = addr;
        return it;
    endfunction

    function automatic logic [ADDR_W-1:0] rand_length();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ADDR_MAX;
            2:       return rand64();
            3, 4, 5: return $urandom_range(1, 16);
            default: return $urandom_range(1, 1 << 20);
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] rand_start();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ADDR_MAX - $urandom_range(0, 255);
            2, 3:    return seg_start[$urandom_range(0, DEPTH - 1)] + $urandom_range(0, 64);
            default: return rand64();
        endcase
    endfunction

    function automatic logic [TYPE_W-1:0] rand_type();
        case ($urandom_range(0, 7))
            0:       return TYPE_NULL;
            1:       return TYPE_NOBITS;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_item random_load(int idx);
        return load_item(idx, rand_start(), rand_length(), rand64(), rand_type());
    endfunction

    function automatic logic [ADDR_W-1:0] near_segment();
        int                lim;
        int                j;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] len;
        lim  = (tbl_count == 0) ? DEPTH : ((tbl_count > DEPTH) ? DEPTH : int'(tbl_count));
        j    = $urandom_range(0, lim - 1);
        base = seg_start[j];
        len  = seg_len[j];
        case ($urandom_range(0, 7))
            0:       return base;
            1:       return base + len - 1;
            2:       return base + len;
            3:       return base - 1;
            default: return base + ((len == 0) ? '0 : rand64() % len);
        endcase
    endfunction

    function automatic t_item random_item();
        if ($urandom_range(0, 99) < load_pct) return random_load($urandom_range(0, DEPTH - 1));
        if ($urandom_range(0, 99) < 85) return query_item(near_segment());
        return query_item(rand64());
    endfunction

    task automatic note_accept(t_item it);
        n_items++;
        if (it.kind == KIND_LOAD) begin
            seg_start[it.index] = it.start;
            seg_len[it.index]   = it.length;
            seg_foff[it.index]  = it.foff;
            seg_skip[it.index]  = (it.etype == TYPE_NULL) || (it.etype == TYPE_NOBITS);
            n_loads++;
        end else begin
            pending_offsets.push_back(translate_address(it.qaddr));
            n_queries++;
        end
    endtask

    task automatic send_item(t_item it);
        i_in_valid          <= 1'b1;
        i_kind              <= it.kind;
        i_entry_index       <= it.index;
        i_entry_address     <= it.start;
        i_entry_length      <= it.length;
        i_entry_file_offset <= it.foff;
        i_entry_type        <= it.etype;
        i_query_address     <= it.qaddr;
        do @(posedge i_clk); while (o_in_stall);
        note_accept(it);
    endtask

    task automatic idle(int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic offer(t_item it);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gappy) idle($urandom_range(1, 12));
        end
        burst_left--;
        send_item(it);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_offsets.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_EXEC_MODE:    mode_exec       = data[0];
            CFG_TABLE_OFFSET: tbl_offset      = data;
            CFG_ENTRY_COUNT:  tbl_count       = data[CNT_W-1:0];
            CFG_ENTRY_BYTES:  tbl_entry_bytes = data[CNT_W-1:0];
            CFG_IMAGE_SIZE:   img_size        = data;
            default: ;
        endcase
    endtask

    task automatic set_config(logic mode, logic [ADDR_W-1:0] toff, logic [CNT_W-1:0] count,
                              logic [CNT_W-1:0] ebytes, logic [ADDR_W-1:0] isize);
        drain();
        write_reg(CFG_EXEC_MODE, {63'b0, mode});
        write_reg(CFG_TABLE_OFFSET, toff);
        write_reg(CFG_ENTRY_COUNT, ADDR_W'(count));
        write_reg(CFG_ENTRY_BYTES, ADDR_W'(ebytes));
        write_reg(CFG_IMAGE_SIZE, isize);
        i_cfg_we <= 1'b0;
        n_configs++;
    endtask

    task automatic random_config();
        logic               mode;
        logic [ADDR_W-1:0]  toff;
        logic [ADDR_W-1:0]  isize;
        logic [CNT_W-1:0]   count;
        logic [CNT_W-1:0]   ebytes;
        logic [TSIZE_W-1:0] tsize;
        logic [ADDR_W:0]    tend;
        mode = $urandom_range(0, 1);
        case ($urandom_range(0, 9))
            0:       count = $urandom_range(65, 127);
            1:       count = $urandom_range(1, 3);
            default: count = $urandom_range(1, 64);
        endcase
        ebytes = ($urandom_range(0, 9) < 6) ? $urandom_range(1, 64) : $urandom_range(0, 127);
        tsize  = ebytes * count;
        case ($urandom_range(0, 3))
            0:       toff = 1;
            1:       toff = ADDR_MAX - tsize;
            2:       toff = {32'h0, $urandom()} | 1;
            default: toff = rand64() | 1;
        endcase
        if (toff > ADDR_MAX - tsize) toff = ADDR_MAX - tsize - $urandom_range(0, 1000);
        tend = {1'b0, toff} + tsize;
        case ($urandom_range(0, 3))
            0:       isize = tend[ADDR_W-1:0];
            1:       isize = ADDR_MAX;
            default: isize = (tend[ADDR_W-1:0] > ADDR_MAX - 65535) ? ADDR_MAX :
                             tend[ADDR_W-1:0] + $urandom_range(0, 65535);
        endcase
        if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 3))
                0: toff = '0;
                1: count = '0;
                2: isize = tend[ADDR_W-1:0] - 1;
                default: begin
                    count  = $urandom_range(1, 64);
                    ebytes = $urandom_range(1, 64);
                    tsize  = ebytes * count;
                    toff   = ADDR_MAX - $urandom_range(0, int'(tsize) - 1);
                    isize  = ADDR_MAX;
                end
            endcase
        end
        set_config(mode, toff, count, ebytes, isize);
    endtask

    task automatic test_fill_table();
        for (int i = 0; i < DEPTH; i++) offer(random_load(i));
    endtask

    task automatic test_corner_cases();
        set_config(1'b0, 64'd1, 7'd4, 7'd64, 64'd257);
        offer(load_item(0, 64'h1000, 64'h0, 64'hA000, TYPE_NULL));
        offer(load_item(1, 64'h1000, 64'h100, 64'hB000, TYPE_NOBITS));
        offer(load_item(2, 64'h1000, 64'h100, 64'hC000, 32'd1));
        offer(load_item(3, 64'hFFFF_FFFF_FFFF_FF00, ADDR_MAX, 64'hFFFF_FFFF_FFFF_FFF0,
                        32'hFFFF_FFFF));
        offer(query_item(64'h1000));
        offer(query_item(64'h10FF));
        offer(query_item(64'h1100));
        offer(query_item(64'h0FFF));
        offer(query_item(ADDR_MAX));
        offer(query_item(64'h0));
        set_config(1'b1, 64'd1, 7'd4, 7'd64, 64'd257);
        offer(query_item(64'h1000));
        offer(query_item(64'h10FF));
        set_config(1'b1, 64'd0, 7'd4, 7'd64, ADDR_MAX);
        offer(query_item(64'h1000));
        set_config(1'b1, 64'd1, 7'd4, 7'd64, 64'd256);
        offer(query_item(64'h1000));
        set_config(1'b1, ADDR_MAX - 63, 7'd1, 7'd64, ADDR_MAX);
        offer(query_item(64'h1000));
        set_config(1'b0, ADDR_MAX - 192, 7'd3, 7'd64, ADDR_MAX);
        offer(query_item(64'h1000));
        set_config(1'b1, 64'd1, 7'd0, 7'd64, ADDR_MAX);
        offer(query_item(64'h1000));
        set_config(1'b0, 64'd1, 7'd127, 7'd0, 64'd1);
        offer(query_item(seg_start[DEPTH - 1]));
        offer(query_item(ADDR_MAX));
        set_config(1'b1, 64'd1, 7'd127, 7'd127, ADDR_MAX);
        offer(query_item(rand64()));
    endtask

    task automatic test_backpressure();
        set_config(1'b1, 64'd1, 7'd64, 7'd64, ADDR_MAX);
        gappy    = 1'b0;
        hold_req = 1'b1;
        repeat (40) offer(query_item(near_segment()));
        gappy = 1'b1;
    endtask

    task automatic test_random_traffic();
        int n_phase;
        while (n_items < ITEM_TARGET) begin
            random_config();
            gappy    = ($urandom_range(0, 3) != 0);
            load_pct = $urandom_range(5, 40);
            n_phase  = $urandom_range(30, 150);
            repeat (n_phase) offer(random_item());
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        t_stall_mode mode;
        int          run_left;
        mode     = STALL_NONE;
        run_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (run_left == 0) begin
                    mode     = t_stall_mode'($urandom_range(0, 3));
                    run_left = $urandom_range(20, 300);
                end
                run_left--;
                case (mode)
                    STALL_NONE:  i_out_stall <= 1'b0;
                    STALL_LIGHT: i_out_stall <= ($urandom_range(0, 7) == 0);
                    STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default:     i_out_stall <= ~i_out_stall;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_offsets.size() == 0) begin
                $error("result with no query waiting: found %0d file_offset 0x%h",
                       o_found, o_file_offset);
                n_fail++;
            end else begin
                want = pending_offsets.pop_front();
                n_results++;
                if (want.found) n_hits++;
                if (o_found !== want.found) begin
                    $error("found: expected %0d actual %0d", want.found, o_found);
                    n_fail++;
                end
                if (o_file_offset !== want.offset) begin
                    $error("file_offset: expected 0x%h actual 0x%h", want.offset, o_file_offset);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        #20000000;
        $display("FAIL segment_address_to_file_offset");
        $finish;
    end

    initial begin
        for (int i = 0; i < DEPTH; i++) begin
            seg_start[i] = '0;
            seg_len[i]   = '0;
            seg_foff[i]  = '0;
            seg_skip[i]  = 1'b0;
        end
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_index         <= CFG_EXEC_MODE;
        i_cfg_data          <= '0;
        i_in_valid          <= 1'b0;
        i_kind              <= KIND_LOAD;
        i_entry_index       <= '0;
        i_entry_address     <= '0;
        i_entry_length      <= '0;
        i_entry_file_offset <= '0;
        i_entry_type        <= '0;
        i_query_address     <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_fill_table();
        test_corner_cases();
        test_backpressure();
        test_random_traffic();
        drain();

        $display("Run covered %0d items (%0d table loads, %0d queries) over %0d register settings.",
                 n_items, n_loads, n_queries, n_configs);
        $display("%0d results checked, %0d of them translated to a file offset.",
                 n_results, n_hits);
        if (n_fail == 0) begin
            $display("PASS segment_address_to_file_offset");
        end else begin
            $display("FAIL segment_address_to_file_offset");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/satfo_pkg.sv
hw/rtl/satfo_ram.sv
hw/rtl/satfo_dp.sv
hw/rtl/satfo_ctrl.sv
hw/rtl/segment_address_to_file_offset.sv
dv/testbench.sv
